// ===== rtl/tzpc_pkg.sv =====
package tzpc_pkg;

   localparam int COORD_BITS = 12;
   localparam int TIME_BITS  = 32;
   localparam int MS_BITS    = 16;
   localparam int COUNT_BITS = 4;
   localparam int ADDR_BITS  = 5;
   localparam int DATA_BITS  = 32;

   localparam logic [COORD_BITS-1:0] ZONE_Y_MIN_RST   = COORD_BITS'(240);
   localparam logic [COORD_BITS-1:0] SPLIT_AB_RST     = COORD_BITS'(148);
   localparam logic [COORD_BITS-1:0] SPLIT_BC_RST     = COORD_BITS'(228);
   localparam logic [MS_BITS-1:0]    LONG_MS_A_RST    = MS_BITS'(800);
   localparam logic [MS_BITS-1:0]    LONG_MS_B_RST    = MS_BITS'(800);
   localparam logic [MS_BITS-1:0]    LONG_MS_C_RST    = MS_BITS'(1500);
   localparam logic [MS_BITS-1:0]    SHORT_MIN_MS_RST = MS_BITS'(40);

   typedef enum logic [1:0] {
      ZONE_NONE = 2'd0,
      ZONE_A    = 2'd1,
      ZONE_B    = 2'd2,
      ZONE_C    = 2'd3
   } zone_type;

   typedef enum logic [1:0] {
      BUTTON_A = 2'd0,
      BUTTON_B = 2'd1,
      BUTTON_C = 2'd2
   } button_type;

   typedef enum logic {
      KIND_SHORT = 1'b0,
      KIND_LONG  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      REG_ZONE_Y_MIN   = 3'd0,
      REG_SPLIT_AB     = 3'd1,
      REG_SPLIT_BC     = 3'd2,
      REG_LONG_MS_A    = 3'd3,
      REG_LONG_MS_B    = 3'd4,
      REG_LONG_MS_C    = 3'd5,
      REG_SHORT_MIN_MS = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] zone_y_min;
      logic [COORD_BITS-1:0] split_ab;
      logic [COORD_BITS-1:0] split_bc;
      logic [MS_BITS-1:0]    long_ms_a;
      logic [MS_BITS-1:0]    long_ms_b;
      logic [MS_BITS-1:0]    long_ms_c;
      logic [MS_BITS-1:0]    short_min_ms;
   } cfg_type;

   typedef struct packed {
      zone_type             zone;
      logic [TIME_BITS-1:0] time_ms;
   } poll_type;

endpackage

// ===== rtl/tzpc_zone.sv =====
module tzpc_zone
   import tzpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COUNT_BITS-1:0] req_touch_count,
   input  logic [COORD_BITS-1:0] req_pos_x,
   input  logic [COORD_BITS-1:0] req_pos_y,
   input  logic [TIME_BITS-1:0]  req_time_ms,
   output logic                  poll_valid,
   input  logic                  poll_ready,
   output poll_type              poll
);

   logic     valid_ff;
   logic     valid_in;
   poll_type poll_ff;
   poll_type poll_in;
   zone_type zone;

   always_comb begin
      if (req_touch_count == '0) begin
         zone = ZONE_NONE;
      end else if (req_pos_y < cfg.zone_y_min) begin
         zone = ZONE_NONE;
      end else if (req_pos_x < cfg.split_ab) begin
         zone = ZONE_A;
      end else if (req_pos_x < cfg.split_bc) begin
         zone = ZONE_B;
      end else begin
         zone = ZONE_C;
      end
   end

   assign req_ready = !valid_ff || poll_ready;

   always_comb begin
      valid_in = valid_ff;
      poll_in  = poll_ff;
      if (req_ready) begin
         valid_in        = req_valid;
         poll_in.zone    = zone;
         poll_in.time_ms = req_time_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      poll_ff <= poll_in;
   end

   assign poll_valid = valid_ff;
   assign poll       = poll_ff;

endmodule

// ===== rtl/tzpc_track.sv =====
module tzpc_track
   import tzpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       poll_valid,
   output logic       poll_ready,
   input  poll_type   poll,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_zone_now,
   output logic       rsp_press_started,
   output logic       rsp_gesture_valid,
   output logic [1:0] rsp_gesture_button,
   output logic       rsp_gesture_kind
);

   zone_type             held_zone_ff;
   zone_type             held_zone_in;
   logic [TIME_BITS-1:0] start_time_ff;
   logic [TIME_BITS-1:0] start_time_in;
   logic                 long_fired_ff;
   logic                 long_fired_in;
   logic                 valid_ff;
   logic                 valid_in;
   zone_type             zone_ff;
   zone_type             zone_in;
   logic                 started_ff;
   logic                 started_in;
   logic                 gvalid_ff;
   logic                 gvalid_in;
   button_type           button_ff;
   button_type           button_in;
   kind_type             kind_ff;
   kind_type             kind_in;

   logic [TIME_BITS-1:0] held_for;
   logic [MS_BITS-1:0]   threshold;
   logic                 accept;
   button_type           held_button;

   assign poll_ready = !valid_ff || rsp_ready;
   assign accept     = poll_valid && poll_ready;
   assign held_for   = poll.time_ms - start_time_ff;

   always_comb begin
      case (held_zone_ff)
         ZONE_A:  threshold = cfg.long_ms_a;
         ZONE_B:  threshold = cfg.long_ms_b;
         default: threshold = cfg.long_ms_c;
      endcase
   end

   always_comb begin
      case (held_zone_ff)
         ZONE_A:  held_button = BUTTON_A;
         ZONE_B:  held_button = BUTTON_B;
         default: held_button = BUTTON_C;
      endcase
   end

   always_comb begin
      held_zone_in  = held_zone_ff;
      start_time_in = start_time_ff;
      long_fired_in = long_fired_ff;
      valid_in      = valid_ff && !rsp_ready;
      zone_in       = zone_ff;
      started_in    = started_ff;
      gvalid_in     = gvalid_ff;
      button_in     = button_ff;
      kind_in       = kind_ff;
      if (accept) begin
         valid_in   = 1'b1;
         zone_in    = poll.zone;
         started_in = 1'b0;
         gvalid_in  = 1'b0;
         button_in  = BUTTON_A;
         kind_in    = KIND_SHORT;
         if (poll.zone != held_zone_ff) begin
            if (held_zone_ff != ZONE_NONE && !long_fired_ff &&
                held_for >= TIME_BITS'(cfg.short_min_ms)) begin
               gvalid_in = 1'b1;
               button_in = held_button;
            end
            held_zone_in  = poll.zone;
            start_time_in = poll.time_ms;
            long_fired_in = 1'b0;
            started_in    = (poll.zone != ZONE_NONE);
         end else if (held_zone_ff != ZONE_NONE && !long_fired_ff &&
                      held_for >= TIME_BITS'(threshold)) begin
            long_fired_in = 1'b1;
            gvalid_in     = 1'b1;
            button_in     = held_button;
            kind_in       = KIND_LONG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_zone_ff  <= ZONE_NONE;
         start_time_ff <= '0;
         long_fired_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         held_zone_ff  <= held_zone_in;
         start_time_ff <= start_time_in;
         long_fired_ff <= long_fired_in;
         valid_ff      <= valid_in;
      end
      zone_ff    <= zone_in;
      started_ff <= started_in;
      gvalid_ff  <= gvalid_in;
      button_ff  <= button_in;
      kind_ff    <= kind_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_zone_now       = zone_ff;
   assign rsp_press_started  = started_ff;
   assign rsp_gesture_valid  = gvalid_ff;
   assign rsp_gesture_button = button_ff;
   assign rsp_gesture_kind   = kind_ff;

`ifndef ASSERT_OFF
   a_idle_not_fired: assert property (@(posedge clock) disable iff (reset)
      held_zone_ff == ZONE_NONE |-> !long_fired_ff)
      else $error("long press flag set with no zone held");

   a_long_not_start: assert property (@(posedge clock) disable iff (reset)
      valid_ff && gvalid_ff && kind_ff == KIND_LONG |-> !started_ff)
      else $error("long press reported on a press start");

   a_long_sets_flag: assert property (@(posedge clock) disable iff (reset)
      accept && gvalid_in && kind_in == KIND_LONG |=> long_fired_ff)
      else $error("long press reported without setting the fired flag");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !gvalid_ff |-> button_ff == BUTTON_A && kind_ff == KIND_SHORT)
      else $error("gesture fields not cleared without a gesture");

   a_start_matches: assert property (@(posedge clock) disable iff (reset)
      valid_ff && started_ff |-> zone_ff == held_zone_ff && zone_ff != ZONE_NONE)
      else $error("press start does not match the held zone");
`endif

endmodule

// ===== rtl/touch_zone_press_classifier.sv =====
// channel | ports                                          | direction
// req     | req_valid/ready, touch_count, pos_x/y, time_ms | in
// rsp     | rsp_valid/ready, zone_now, press_started,      | out
//         | gesture_valid, gesture_button, gesture_kind    |
// csr     | csr_psel/penable/pwrite/paddr/pwdata/prdata    | in/out
//
// One item per cycle while rsp_ready holds; each item is registered in stage one, then in stage two, before rsp.
// Stage one classifies the zone, stage two updates the held-zone tracker and the result.
// Each stage holds its item while the next one stalls; req_ready is high when stage one is empty or stage two takes.
// Synchronous reset empties both stages, clears the tracker and loads the default registers.
module touch_zone_press_classifier
   import tzpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COUNT_BITS-1:0] req_touch_count,
   input  logic [COORD_BITS-1:0] req_pos_x,
   input  logic [COORD_BITS-1:0] req_pos_y,
   input  logic [TIME_BITS-1:0]  req_time_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_zone_now,
   output logic                  rsp_press_started,
   output logic                  rsp_gesture_valid,
   output logic [1:0]            rsp_gesture_button,
   output logic                  rsp_gesture_kind,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_BITS-1:0]  csr_paddr,
   input  logic [DATA_BITS-1:0]  csr_pwdata,
   output logic [DATA_BITS-1:0]  csr_prdata,
   output logic                  csr_pready
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          csr_write;
   logic          poll_valid;
   logic          poll_ready;
   poll_type      poll;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = reg_index_type'(csr_paddr[ADDR_BITS-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            REG_ZONE_Y_MIN:   cfg_in.zone_y_min   = csr_pwdata[COORD_BITS-1:0];
            REG_SPLIT_AB:     cfg_in.split_ab     = csr_pwdata[COORD_BITS-1:0];
            REG_SPLIT_BC:     cfg_in.split_bc     = csr_pwdata[COORD_BITS-1:0];
            REG_LONG_MS_A:    cfg_in.long_ms_a    = csr_pwdata[MS_BITS-1:0];
            REG_LONG_MS_B:    cfg_in.long_ms_b    = csr_pwdata[MS_BITS-1:0];
            REG_LONG_MS_C:    cfg_in.long_ms_c    = csr_pwdata[MS_BITS-1:0];
            REG_SHORT_MIN_MS: cfg_in.short_min_ms = csr_pwdata[MS_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_ZONE_Y_MIN:   csr_prdata = DATA_BITS'(cfg_ff.zone_y_min);
         REG_SPLIT_AB:     csr_prdata = DATA_BITS'(cfg_ff.split_ab);
         REG_SPLIT_BC:     csr_prdata = DATA_BITS'(cfg_ff.split_bc);
         REG_LONG_MS_A:    csr_prdata = DATA_BITS'(cfg_ff.long_ms_a);
         REG_LONG_MS_B:    csr_prdata = DATA_BITS'(cfg_ff.long_ms_b);
         REG_LONG_MS_C:    csr_prdata = DATA_BITS'(cfg_ff.long_ms_c);
         REG_SHORT_MIN_MS: csr_prdata = DATA_BITS'(cfg_ff.short_min_ms);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zone_y_min   <= ZONE_Y_MIN_RST;
         cfg_ff.split_ab     <= SPLIT_AB_RST;
         cfg_ff.split_bc     <= SPLIT_BC_RST;
         cfg_ff.long_ms_a    <= LONG_MS_A_RST;
         cfg_ff.long_ms_b    <= LONG_MS_B_RST;
         cfg_ff.long_ms_c    <= LONG_MS_C_RST;
         cfg_ff.short_min_ms <= SHORT_MIN_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tzpc_zone u_zone (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_touch_count (req_touch_count),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_time_ms     (req_time_ms),
      .poll_valid      (poll_valid),
      .poll_ready      (poll_ready),
      .poll            (poll)
   );

   tzpc_track u_track (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .poll_valid         (poll_valid),
      .poll_ready         (poll_ready),
      .poll               (poll),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_zone_now       (rsp_zone_now),
      .rsp_press_started  (rsp_press_started),
      .rsp_gesture_valid  (rsp_gesture_valid),
      .rsp_gesture_button (rsp_gesture_button),
      .rsp_gesture_kind   (rsp_gesture_kind)
   );

endmodule

// ===== dv/touch_zone_press_classifier_tb.sv =====
module touch_zone_press_classifier_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tzpc_pkg::*;

   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int STALL_LIMIT = 4000;
   localparam logic [ADDR_BITS-1:0] UNMAPPED_ADDR = ADDR_BITS'(4 * (int'(REG_SHORT_MIN_MS) + 1));

   typedef struct {
      zone_type   zone;
      bit         started;
      bit         valid;
      button_type button;
      kind_type   kind;
   } press_result_type;

   class press_tracker;
      cfg_type              cfg;
      zone_type             held;
      logic [TIME_BITS-1:0] start_ms;
      bit                   fired;
      press_result_type     expected_press[$];
      int                   mismatches;

      function new();
         cfg.zone_y_min   = ZONE_Y_MIN_RST;
         cfg.split_ab     = SPLIT_AB_RST;
         cfg.split_bc     = SPLIT_BC_RST;
         cfg.long_ms_a    = LONG_MS_A_RST;
         cfg.long_ms_b    = LONG_MS_B_RST;
         cfg.long_ms_c    = LONG_MS_C_RST;
         cfg.short_min_ms = SHORT_MIN_MS_RST;
         held       = ZONE_NONE;
         start_ms   = '0;
         fired      = 1'b0;
         mismatches = 0;
      endfunction

      function void write_reg(int idx, logic [DATA_BITS-1:0] data);
         if (idx > int'(REG_SHORT_MIN_MS)) return;
         case (reg_index_type'(idx))
            REG_ZONE_Y_MIN: cfg.zone_y_min   = data[COORD_BITS-1:0];
            REG_SPLIT_AB:   cfg.split_ab     = data[COORD_BITS-1:0];
            REG_SPLIT_BC:   cfg.split_bc     = data[COORD_BITS-1:0];
            REG_LONG_MS_A:  cfg.long_ms_a    = data[MS_BITS-1:0];
            REG_LONG_MS_B:  cfg.long_ms_b    = data[MS_BITS-1:0];
            REG_LONG_MS_C:  cfg.long_ms_c    = data[MS_BITS-1:0];
            default:        cfg.short_min_ms = data[MS_BITS-1:0];
         endcase
      endfunction

      function zone_type zone_of(logic [COUNT_BITS-1:0] count, logic [COORD_BITS-1:0] x,
                                 logic [COORD_BITS-1:0] y);
         if (count == '0) return ZONE_NONE;
         if (y < cfg.zone_y_min) return ZONE_NONE;
         if (x < cfg.split_ab) return ZONE_A;
         if (x < cfg.split_bc) return ZONE_B;
         return ZONE_C;
      endfunction

      function logic [MS_BITS-1:0] long_ms_of(zone_type z);
         case (z)
            ZONE_A:  return cfg.long_ms_a;
            ZONE_B:  return cfg.long_ms_b;
            default: return cfg.long_ms_c;
         endcase
      endfunction

      function void note_poll(logic [COUNT_BITS-1:0] count, logic [COORD_BITS-1:0] x,
                              logic [COORD_BITS-1:0] y, logic [TIME_BITS-1:0] t);
         zone_type             hit;
         logic [TIME_BITS-1:0] held_for;
         press_result_type     r;
         hit       = zone_of(count, x, y);
         held_for  = t - start_ms;
         r.zone    = hit;
         r.started = 1'b0;
         r.valid   = 1'b0;
         r.button  = BUTTON_A;
         r.kind    = KIND_SHORT;
         if (hit != held) begin
            if (held != ZONE_NONE && !fired && held_for >= TIME_BITS'(cfg.short_min_ms)) begin
               r.valid  = 1'b1;
               r.button = button_type'(held - 1);
               r.kind   = KIND_SHORT;
            end
            held      = hit;
            start_ms  = t;
            fired     = 1'b0;
            r.started = (hit != ZONE_NONE);
         end else if (held != ZONE_NONE && !fired &&
                      held_for >= TIME_BITS'(long_ms_of(held))) begin
            fired    = 1'b1;
            r.valid  = 1'b1;
            r.button = button_type'(held - 1);
            r.kind   = KIND_LONG;
         end
         expected_press.push_back(r);
      endfunction

      function void check_press(logic [1:0] zone, logic started, logic valid,
                                logic [1:0] button, logic kind);
         press_result_type e;
         if (expected_press.size() == 0) begin
            $error("result with no poll pending: zone_now %0d", zone);
            mismatches++;
            return;
         end
         e = expected_press.pop_front();
         if (zone !== e.zone) begin
            $error("zone_now: expected %0d, actual %0d", e.zone, zone);
            mismatches++;
         end
         if (started !== e.started) begin
            $error("press_started: expected %0d, actual %0d", e.started, started);
            mismatches++;
         end
         if (valid !== e.valid) begin
            $error("gesture_valid: expected %0d, actual %0d", e.valid, valid);
            mismatches++;
         end
         if (button !== e.button) begin
            $error("gesture_button: expected %0d, actual %0d", e.button, button);
            mismatches++;
         end
         if (kind !== e.kind) begin
            $error("gesture_kind: expected %0d, actual %0d", e.kind, kind);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [COUNT_BITS-1:0] req_touch_count = '0;
   logic [COORD_BITS-1:0] req_pos_x = '0;
   logic [COORD_BITS-1:0] req_pos_y = '0;
   logic [TIME_BITS-1:0]  req_time_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_zone_now;
   logic                  rsp_press_started;
   logic                  rsp_gesture_valid;
   logic [1:0]            rsp_gesture_button;
   logic                  rsp_gesture_kind;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [ADDR_BITS-1:0]  csr_paddr = '0;
   logic [DATA_BITS-1:0]  csr_pwdata = '0;
   logic [DATA_BITS-1:0]  csr_prdata;
   logic                  csr_pready;

   press_tracker          tracker = new();
   int                    quiet_cycles = 0;
   int                    ready_mode = 0;
   int                    ready_left = 0;
   int                    burst_left = 0;
   int                    seg_left = 0;
   zone_type              seg_zone = ZONE_NONE;
   logic [TIME_BITS-1:0]  now_ms = '0;

   touch_zone_press_classifier uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_touch_count    (req_touch_count),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_time_ms        (req_time_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_zone_now       (rsp_zone_now),
      .rsp_press_started  (rsp_press_started),
      .rsp_gesture_valid  (rsp_gesture_valid),
      .rsp_gesture_button (rsp_gesture_button),
      .rsp_gesture_kind   (rsp_gesture_kind),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_poll(req_touch_count, req_pos_x, req_pos_y, req_time_ms);
         if (rsp_valid && rsp_ready)
            tracker.check_press(rsp_zone_now, rsp_press_started, rsp_gesture_valid,
                                rsp_gesture_button, rsp_gesture_kind);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("touch_zone_press_classifier_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= int'($urandom_range(0, 3));
         ready_left <= int'($urandom_range(16, 160));
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 1) == 1);
         2:       rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (ready_left % 5 != 0);
      endcase
   end

   task automatic send_poll(input logic [COUNT_BITS-1:0] count, input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y, input logic [TIME_BITS-1:0] t);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_touch_count <= count;
      req_pos_x       <= x;
      req_pos_y       <= y;
      req_time_ms     <= t;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic poll(input logic [COUNT_BITS-1:0] count, input logic [COORD_BITS-1:0] x,
                       input logic [COORD_BITS-1:0] y, input logic [TIME_BITS-1:0] t);
      int gap;
      send_poll(count, x, y, t);
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = int'($urandom_range(0, 40));
      gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
      repeat (gap) @(negedge clock) req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.expected_press.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.write_reg(int'(addr >> 2), data);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [DATA_BITS-1:0] with_noise(int w, logic [DATA_BITS-1:0] v);
      return (DATA_BITS'($urandom) << w) | v;
   endfunction

   task automatic set_config(input cfg_type c);
      logic [DATA_BITS-1:0] field_value [7];
      field_value[REG_ZONE_Y_MIN]   = with_noise(COORD_BITS, DATA_BITS'(c.zone_y_min));
      field_value[REG_SPLIT_AB]     = with_noise(COORD_BITS, DATA_BITS'(c.split_ab));
      field_value[REG_SPLIT_BC]     = with_noise(COORD_BITS, DATA_BITS'(c.split_bc));
      field_value[REG_LONG_MS_A]    = with_noise(MS_BITS, DATA_BITS'(c.long_ms_a));
      field_value[REG_LONG_MS_B]    = with_noise(MS_BITS, DATA_BITS'(c.long_ms_b));
      field_value[REG_LONG_MS_C]    = with_noise(MS_BITS, DATA_BITS'(c.long_ms_c));
      field_value[REG_SHORT_MIN_MS] = with_noise(MS_BITS, DATA_BITS'(c.short_min_ms));
      for (int i = 0; i < $size(field_value); i++)
         csr_write(ADDR_BITS'(i * 4), field_value[i]);
   endtask

   task automatic make_point(input zone_type z, output logic [COUNT_BITS-1:0] count,
                             output logic [COORD_BITS-1:0] x, output logic [COORD_BITS-1:0] y);
      int lo;
      count = COUNT_BITS'($urandom_range(1, 15));
      x     = COORD_BITS'($urandom);
      y     = COORD_BITS'($urandom_range(int'(tracker.cfg.zone_y_min), COORD_MAX));
      case (z)
         ZONE_NONE: begin
            if (tracker.cfg.zone_y_min == '0 || $urandom_range(0, 1) == 1)
               count = '0;
            else
               y = COORD_BITS'($urandom_range(0, int'(tracker.cfg.zone_y_min) - 1));
         end
         ZONE_A: begin
            if (tracker.cfg.split_ab != '0)
               x = COORD_BITS'($urandom_range(0, int'(tracker.cfg.split_ab) - 1));
         end
         ZONE_B: begin
            if (tracker.cfg.split_bc > tracker.cfg.split_ab)
               x = COORD_BITS'($urandom_range(int'(tracker.cfg.split_ab),
                                              int'(tracker.cfg.split_bc) - 1));
         end
         default: begin
            lo = (tracker.cfg.split_ab > tracker.cfg.split_bc) ? int'(tracker.cfg.split_ab)
                                                               : int'(tracker.cfg.split_bc);
            x = COORD_BITS'($urandom_range(lo, COORD_MAX));
         end
      endcase
   endtask

   task automatic directed_polls();
      cfg_type c;
      poll(4'd0,  12'd0,    12'd0,    32'd0);
      poll(4'd1,  12'd0,    12'd4095, 32'd100);
      poll(4'd2,  12'd147,  12'd240,  32'd130);
      poll(4'd0,  12'd4095, 12'd4095, 32'd150);
      poll(4'd1,  12'd148,  12'd240,  32'd200);
      poll(4'd0,  12'd0,    12'd0,    32'd220);
      poll(4'd15, 12'd4095, 12'd4095, 32'd300);
      poll(4'd15, 12'd228,  12'd300,  32'd1799);
      poll(4'd15, 12'd228,  12'd300,  32'd1800);
      poll(4'd15, 12'd3000, 12'd300,  32'd1900);
      poll(4'd0,  12'd0,    12'd0,    32'd2000);
      poll(4'd1,  12'd0,    12'd239,  32'd2100);
      poll(4'd1,  12'd100,  12'd500,  32'd3000);
      poll(4'd1,  12'd200,  12'd500,  32'd3100);
      poll(4'd1,  12'd300,  12'd500,  32'd3120);
      poll(4'd0,  12'd0,    12'd0,    32'd3200);
      poll(4'd1,  12'd10,   12'd4095, 32'hFFFF_FFF0);
      poll(4'd1,  12'd10,   12'd4095, 32'h0000_0320);
      poll(4'd0,  12'd0,    12'd0,    32'h0000_0400);
      poll(4'd3,  12'd50,   12'd260,  32'd5000);
      poll(4'd3,  12'd50,   12'd260,  32'd4990);
      poll(4'd0,  12'd0,    12'd0,    32'hFFFF_FFFF);
      wait_drained();
      c.zone_y_min   = 12'd100;
      c.split_ab     = 12'd2000;
      c.split_bc     = 12'd1000;
      c.long_ms_a    = '0;
      c.long_ms_b    = '0;
      c.long_ms_c    = '0;
      c.short_min_ms = '0;
      set_config(c);
      poll(4'd1,  12'd10,   12'd100,  32'd10);
      poll(4'd1,  12'd1500, 12'd100,  32'd10);
      poll(4'd1,  12'd2500, 12'd100,  32'd11);
      poll(4'd0,  12'd0,    12'd0,    32'd11);
      poll(4'd1,  12'd2000, 12'd99,   32'd12);
   endtask

   task automatic random_phase(input int phase, input int n);
      cfg_type               c;
      int                    roll;
      logic [COUNT_BITS-1:0] count;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [TIME_BITS-1:0]  t;
      wait_drained();
      c.zone_y_min   = COORD_BITS'($urandom);
      c.split_ab     = COORD_BITS'($urandom);
      c.split_bc     = COORD_BITS'($urandom);
      c.long_ms_a    = MS_BITS'($urandom);
      c.long_ms_b    = MS_BITS'($urandom);
      c.long_ms_c    = MS_BITS'($urandom);
      c.short_min_ms = MS_BITS'($urandom);
      case (phase)
         0: c = '0;
         1: c = '1;
         3: ;
         default: begin
            c.long_ms_a    = MS_BITS'($urandom_range(0, 400));
            c.long_ms_b    = MS_BITS'($urandom_range(0, 400));
            c.long_ms_c    = MS_BITS'($urandom_range(0, 400));
            c.short_min_ms = MS_BITS'($urandom_range(0, 60));
            if (phase == 2) begin
               c.zone_y_min = COORD_BITS'($urandom_range(0, 2000));
               c.split_ab   = COORD_BITS'($urandom_range(1000, COORD_MAX));
               c.split_bc   = COORD_BITS'($urandom_range(0, int'(c.split_ab)));
            end else begin
               c.split_ab   = COORD_BITS'($urandom_range(1, 4000));
               c.split_bc   = COORD_BITS'($urandom_range(int'(c.split_ab) + 1, COORD_MAX));
            end
         end
      endcase
      set_config(c);
      if (phase == 3) csr_write(UNMAPPED_ADDR, DATA_BITS'($urandom));
      for (int i = 0; i < n; i++) begin
         if (seg_left == 0) begin
            seg_zone = zone_type'($urandom_range(0, 3));
            seg_left = int'($urandom_range(1, 25));
         end
         seg_left--;
         roll = int'($urandom_range(0, 99));
         if (roll < 84)      now_ms += TIME_BITS'($urandom_range(0, 40));
         else if (roll < 92) now_ms += TIME_BITS'($urandom_range(41, 3000));
         else if (roll < 95) now_ms -= TIME_BITS'($urandom_range(1, 50));
         else if (roll < 97) now_ms = TIME_BITS'($urandom);
         else if (roll < 98) now_ms += TIME_BITS'(70000);
         else                now_ms = '1 - TIME_BITS'($urandom_range(0, 300));
         make_point(seg_zone, count, x, y);
         t = now_ms;
         if ($urandom_range(0, 99) < 8) begin
            count = COUNT_BITS'($urandom);
            case ($urandom_range(0, 2))
               0: begin
                  x = COORD_BITS'($urandom);
                  y = COORD_BITS'($urandom);
               end
               1: begin
                  x = tracker.cfg.split_ab - COORD_BITS'($urandom_range(0, 1));
                  y = tracker.cfg.zone_y_min;
               end
               default: begin
                  x = tracker.cfg.split_bc - COORD_BITS'($urandom_range(0, 1));
                  y = tracker.cfg.zone_y_min - COORD_BITS'(1);
               end
            endcase
            if ($urandom_range(0, 1) == 1) t = TIME_BITS'($urandom);
         end
         poll(count, x, y, t);
         if ($urandom_range(0, 199) == 0) wait_drained();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      directed_polls();
      for (int p = 0; p < 9; p++) random_phase(p, 100);
      wait_drained();
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_press.size() == 0)
         $display("touch_zone_press_classifier_tb: done, clean");
      else
         $display("touch_zone_press_classifier_tb: done, errors");
      $finish;
   end

endmodule
